/* hw/rtl/srle_pkg.sv */
// ----------------------------------------------------------------------------
// srle_pkg: shared types and constants of the S-record line encoder
// Command codes, register indexes, sequencer states and the fixed record text.
// ----------------------------------------------------------------------------
`default_nettype none

package srle_pkg;

  typedef enum logic [1:0] {
    OP_HEADER = 2'd0,
    OP_START  = 2'd1,
    OP_DATA   = 2'd2,
    OP_TERM   = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    REG_ADDRESS_BYTES = 1'b0,
    REG_ADDR_OFFSET   = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STR,
    ST_ERR,
    ST_REC_S,
    ST_REC_TYPE,
    ST_REC_HEX,
    ST_REC_NL
  } state_t;

  typedef enum logic [1:0] {
    STR_HDR,
    STR_TERM2,
    STR_TERM3,
    STR_TERM4
  } str_t;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_S  = 8'h53;
  localparam logic [7:0] CHAR_1  = 8'h31;

  localparam int HDR_LEN   = 34;
  localparam int TERM2_LEN = 10;
  localparam int TERM3_LEN = 12;
  localparam int TERM4_LEN = 14;

  localparam logic [8*HDR_LEN-1:0]   HDR_TEXT   = "S00F000068656C6C6F202020202000003C";
  localparam logic [8*TERM2_LEN-1:0] TERM2_TEXT = "S9030000FC";
  localparam logic [8*TERM3_LEN-1:0] TERM3_TEXT = "S804000000FB";
  localparam logic [8*TERM4_LEN-1:0] TERM4_TEXT = "S70500000000FA";

  // Index of the newline, which follows the last text character.
  function automatic logic [5:0] str_len(input str_t s);
    case (s)
      STR_HDR:   return 6'(HDR_LEN);
      STR_TERM2: return 6'(TERM2_LEN);
      STR_TERM3: return 6'(TERM3_LEN);
      STR_TERM4: return 6'(TERM4_LEN);
      default:   return 6'(HDR_LEN);
    endcase
  endfunction

  function automatic logic [7:0] str_char(input str_t s, input logic [5:0] idx);
    logic [7:0] ch;
    ch = CHAR_LF;
    case (s)
      STR_HDR:   if (idx < 6'(HDR_LEN))
                   ch = HDR_TEXT[8*(HDR_LEN-1-int'(idx)) +: 8];
      STR_TERM2: if (idx < 6'(TERM2_LEN))
                   ch = TERM2_TEXT[8*(TERM2_LEN-1-int'(idx)) +: 8];
      STR_TERM3: if (idx < 6'(TERM3_LEN))
                   ch = TERM3_TEXT[8*(TERM3_LEN-1-int'(idx)) +: 8];
      STR_TERM4: if (idx < 6'(TERM4_LEN))
                   ch = TERM4_TEXT[8*(TERM4_LEN-1-int'(idx)) +: 8];
      default:   ch = CHAR_LF;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + {4'd0, nib};
    else             return 8'h37 + {4'd0, nib};
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/srecord_line_encoder_unit.sv */
// ----------------------------------------------------------------------------
// srecord_line_encoder_unit: S-record (S19/S28/S37) line encoder
// Turns header, region, data and termination commands into ASCII record text.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | tdata (low bit up)                 | tuser   | tlast
//  --------+-----------+------------------------------------+---------+---------------
//  in_     | slave     | region_address[31:0], data_byte    | opcode  | last_in_region
//  out_    | master    | out_char[7:0]                      | range_error | end_of_run
//  cfg_    | write     | index 0 address_bytes, 1 address offset (cfg_wdata) |  |
//
// One character leaves the block per cycle while out_tready is high. An item
// that yields no character is taken while the sequencer stays idle; for any
// other item the character sequencer walks through its characters before it
// takes the next item. The record bytes live in a buffer memory with one write
// and one read port, whose registered read is addressed from the next byte
// index so that it is ready for the hex digits that need it.
// Reset (rst_n low at a clock edge) clears the sequencer and region state; the
// buffer memory is not cleared, since only written entries are ever read.
// A stalled out_tready holds the character register and the sequencer; the
// next item is taken while the last character of the previous one still waits.
//
`default_nettype none

module srecord_line_encoder_unit #(
  parameter int RECORD_DATA_BYTES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input item stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // region_address[31:0], data_byte[39:32]
  input  wire logic [1:0]  in_tuser,   // opcode[1:0]
  input  wire logic        in_tlast,   // last_in_region
  // Result stream, one character per transfer.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // out_char[7:0]
  output logic             out_tuser,  // range_error
  output logic             out_tlast,  // end_of_run
  // Configuration writes.
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  localparam int AW  = (RECORD_DATA_BYTES > 1) ? $clog2(RECORD_DATA_BYTES) : 1;
  localparam int FW  = $clog2(RECORD_DATA_BYTES + 1);
  localparam int BIW = $clog2(RECORD_DATA_BYTES + 6);

  // Configuration registers.
  logic [2:0]  address_bytes_r;
  logic [31:0] addr_offset_r;

  // Region state.
  logic [FW-1:0] fill_r, fill_nxt;
  logic [32:0]   rec_addr_r, rec_addr_nxt;
  logic          failed_r, failed_nxt;

  // Record buffer memory.
  logic [7:0]    chunk_mem [RECORD_DATA_BYTES];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    rd_data_r;

  // Sequencer.
  srle_pkg::state_t state_r, state_nxt;
  srle_pkg::str_t   str_sel_r, str_sel_nxt;
  logic [5:0]       str_idx_r, str_idx_nxt;
  logic [31:0]      em_addr_r, em_addr_nxt;
  logic [2:0]       em_w_r, em_w_nxt;
  logic [7:0]       em_len_r, em_len_nxt;
  logic [BIW-1:0]   em_last_idx_r, em_last_idx_nxt;
  logic [BIW-1:0]   byte_idx_r, byte_idx_nxt;
  logic             nib_r, nib_nxt;
  logic [7:0]       sum_r, sum_nxt;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_err_r, out_err_nxt;

  // Combinational helpers.
  srle_pkg::op_t  op;
  logic           in_fire;
  logic           gen_ok;
  logic [2:0]     width;
  logic [FW-1:0]  fill_new;
  logic [33:0]    last_addr;
  logic           over_range;
  logic           emit_now;
  logic [BIW-1:0] w_ext;
  logic [BIW-1:0] data_base;
  logic [BIW-1:0] data_pos;
  logic [1:0]     addr_sel;
  logic [7:0]     cur_byte;

  assign op      = srle_pkg::op_t'(in_tuser);
  assign in_fire = in_tvalid && in_tready;
  assign gen_ok  = !out_valid_r || out_tready;

  assign in_tready  = (state_r == srle_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tuser  = out_err_r;
  assign out_tlast  = out_last_r;

  // Widths outside 2..4 clamp to the nearest legal width.
  always_comb begin
    if (address_bytes_r < 3'd2)      width = 3'd2;
    else if (address_bytes_r > 3'd4) width = 3'd4;
    else                             width = address_bytes_r;
  end

  // Data item: the byte goes into the buffer, and a full buffer or the last
  // byte of the region closes the record. The range check looks at the
  // record's last address against the top of the selected address space.
  always_comb begin
    fill_new  = (fill_r < FW'(RECORD_DATA_BYTES)) ? fill_r + FW'(1) : fill_r;
    last_addr = {1'b0, rec_addr_r} + 34'(fill_new) - 34'd1;
    case (width)
      3'd2:    over_range = |last_addr[33:16];
      3'd3:    over_range = |last_addr[33:24];
      default: over_range = |last_addr[33:32];
    endcase
    emit_now = (fill_new >= FW'(RECORD_DATA_BYTES)) || in_tlast;
  end

  assign mem_we    = in_fire && (op == srle_pkg::OP_DATA) && !failed_r &&
                     (fill_r < FW'(RECORD_DATA_BYTES));
  assign mem_waddr = fill_r[AW-1:0];

  // Byte list of a record: length, address bytes, data bytes, checksum.
  always_comb begin
    w_ext     = BIW'(em_w_r);
    data_base = w_ext + BIW'(1);
    addr_sel  = 2'(w_ext - byte_idx_r);
    if (byte_idx_r == '0)
      cur_byte = em_len_r;
    else if (byte_idx_r <= w_ext)
      cur_byte = em_addr_r[8*addr_sel +: 8];
    else if (byte_idx_r < em_last_idx_r)
      cur_byte = rd_data_r;
    else
      cur_byte = ~sum_r;
  end

  // The buffer is read at the data position of the next byte index, so the
  // registered read data always matches the current byte index.
  assign data_pos  = byte_idx_nxt - data_base;
  assign mem_raddr = data_pos[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      chunk_mem[mem_waddr] <= in_tdata[39:32];
    end
    rd_data_r <= chunk_mem[mem_raddr];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srle_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (op)
            srle_pkg::OP_HEADER: state_nxt = srle_pkg::ST_STR;
            srle_pkg::OP_TERM:   state_nxt = srle_pkg::ST_STR;
            srle_pkg::OP_DATA: begin
              if (!failed_r && emit_now) begin
                state_nxt = over_range ? srle_pkg::ST_ERR : srle_pkg::ST_REC_S;
              end
            end
            default: state_nxt = srle_pkg::ST_IDLE;
          endcase
        end
      end
      srle_pkg::ST_STR: begin
        if (gen_ok && (str_idx_r == srle_pkg::str_len(str_sel_r))) begin
          state_nxt = srle_pkg::ST_IDLE;
        end
      end
      srle_pkg::ST_ERR: begin
        if (gen_ok) state_nxt = srle_pkg::ST_IDLE;
      end
      srle_pkg::ST_REC_S: begin
        if (gen_ok) state_nxt = srle_pkg::ST_REC_TYPE;
      end
      srle_pkg::ST_REC_TYPE: begin
        if (gen_ok) state_nxt = srle_pkg::ST_REC_HEX;
      end
      srle_pkg::ST_REC_HEX: begin
        if (gen_ok && nib_r && (byte_idx_r == em_last_idx_r)) begin
          state_nxt = srle_pkg::ST_REC_NL;
        end
      end
      srle_pkg::ST_REC_NL: begin
        if (gen_ok) state_nxt = srle_pkg::ST_IDLE;
      end
      default: state_nxt = srle_pkg::ST_IDLE;
    endcase
  end

  // Datapath and output register.
  always_comb begin
    fill_nxt        = fill_r;
    rec_addr_nxt    = rec_addr_r;
    failed_nxt      = failed_r;
    str_sel_nxt     = str_sel_r;
    str_idx_nxt     = str_idx_r;
    em_addr_nxt     = em_addr_r;
    em_w_nxt        = em_w_r;
    em_len_nxt      = em_len_r;
    em_last_idx_nxt = em_last_idx_r;
    byte_idx_nxt    = byte_idx_r;
    nib_nxt         = nib_r;
    sum_nxt         = sum_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_char_nxt    = out_char_r;
    out_last_nxt    = out_last_r;
    out_err_nxt     = out_err_r;

    case (state_r)
      srle_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (op)
            srle_pkg::OP_HEADER: begin
              str_sel_nxt = srle_pkg::STR_HDR;
              str_idx_nxt = '0;
            end
            srle_pkg::OP_START: begin
              fill_nxt     = '0;
              failed_nxt   = 1'b0;
              rec_addr_nxt = {1'b0, in_tdata[31:0]} + {1'b0, addr_offset_r};
            end
            srle_pkg::OP_DATA: begin
              if (!failed_r) begin
                fill_nxt = fill_new;
                if (emit_now) begin
                  fill_nxt = '0;
                  if (over_range) begin
                    failed_nxt = 1'b1;
                  end else begin
                    rec_addr_nxt = rec_addr_r + 33'(fill_new);
                  end
                  em_addr_nxt     = rec_addr_r[31:0];
                  em_w_nxt        = width;
                  em_len_nxt      = 8'(width) + 8'(fill_new) + 8'd1;
                  em_last_idx_nxt = BIW'(fill_new) + BIW'(width) + BIW'(1);
                  byte_idx_nxt    = '0;
                  nib_nxt         = 1'b0;
                  sum_nxt         = '0;
                end
              end
            end
            default: begin
              fill_nxt    = '0;
              str_idx_nxt = '0;
              case (width)
                3'd2:    str_sel_nxt = srle_pkg::STR_TERM2;
                3'd3:    str_sel_nxt = srle_pkg::STR_TERM3;
                default: str_sel_nxt = srle_pkg::STR_TERM4;
              endcase
            end
          endcase
        end
      end
      srle_pkg::ST_STR: begin
        if (gen_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = srle_pkg::str_char(str_sel_r, str_idx_r);
          out_last_nxt  = (str_idx_r == srle_pkg::str_len(str_sel_r));
          out_err_nxt   = 1'b0;
          str_idx_nxt   = str_idx_r + 6'd1;
        end
      end
      srle_pkg::ST_ERR: begin
        if (gen_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = 8'h00;
          out_last_nxt  = 1'b1;
          out_err_nxt   = 1'b1;
        end
      end
      srle_pkg::ST_REC_S: begin
        if (gen_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = srle_pkg::CHAR_S;
          out_last_nxt  = 1'b0;
          out_err_nxt   = 1'b0;
        end
      end
      srle_pkg::ST_REC_TYPE: begin
        if (gen_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = srle_pkg::CHAR_1 + 8'(em_w_r) - 8'd2;
          out_last_nxt  = 1'b0;
          out_err_nxt   = 1'b0;
        end
      end
      srle_pkg::ST_REC_HEX: begin
        if (gen_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = srle_pkg::hex_char(nib_r ? cur_byte[3:0] : cur_byte[7:4]);
          out_last_nxt  = 1'b0;
          out_err_nxt   = 1'b0;
          nib_nxt       = !nib_r;
          if (nib_r) begin
            sum_nxt = sum_r + cur_byte;
            if (byte_idx_r != em_last_idx_r) byte_idx_nxt = byte_idx_r + BIW'(1);
          end
        end
      end
      srle_pkg::ST_REC_NL: begin
        if (gen_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = srle_pkg::CHAR_LF;
          out_last_nxt  = 1'b1;
          out_err_nxt   = 1'b0;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      address_bytes_r <= 3'd2;
      addr_offset_r   <= '0;
    end else if (cfg_we) begin
      case (srle_pkg::reg_idx_t'(cfg_index))
        srle_pkg::REG_ADDRESS_BYTES: address_bytes_r <= cfg_wdata[2:0];
        srle_pkg::REG_ADDR_OFFSET:   addr_offset_r   <= cfg_wdata;
        default:                     addr_offset_r   <= addr_offset_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srle_pkg::ST_IDLE;
      fill_r      <= '0;
      rec_addr_r  <= '0;
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      rec_addr_r  <= rec_addr_nxt;
      failed_r    <= failed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    str_sel_r     <= str_sel_nxt;
    str_idx_r     <= str_idx_nxt;
    em_addr_r     <= em_addr_nxt;
    em_w_r        <= em_w_nxt;
    em_len_r      <= em_len_nxt;
    em_last_idx_r <= em_last_idx_nxt;
    byte_idx_r    <= byte_idx_nxt;
    nib_r         <= nib_nxt;
    sum_r         <= sum_nxt;
    out_char_r    <= out_char_nxt;
    out_last_r    <= out_last_nxt;
    out_err_r     <= out_err_nxt;
  end

  // An error result is a lone zero character that closes its run.
  a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_last_r && (out_char_r == 8'h00)))
    else $error("error result is not a lone zero character");

  // Between items the buffer never holds a complete record.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srle_pkg::ST_IDLE) |-> (fill_r < FW'(RECORD_DATA_BYTES)))
    else $error("buffer fill reached a full record while idle");

  // The hex sequencer never walks past the checksum byte.
  a_byte_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srle_pkg::ST_REC_HEX) |-> (byte_idx_r <= em_last_idx_r))
    else $error("record byte index ran past the checksum");

  // A new record starts only after a data item closed it.
  a_rec_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srle_pkg::ST_IDLE && state_nxt == srle_pkg::ST_REC_S) |->
      (in_fire && op == srle_pkg::OP_DATA && !failed_r))
    else $error("record started without a closing data item");

endmodule

`default_nettype wire

/* tb/sv/srecord_line_encoder_unit_checker.sv */
// ----------------------------------------------------------------------------
// srecord_line_encoder_unit_checker: S-record encoder scoreboard
// Watches the command, character and register write ports. It predicts every
// character of the record text and compares it with what the encoder emits.
// ----------------------------------------------------------------------------

module srecord_line_encoder_unit_checker #(
  parameter int DATA_BYTES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [39:0] in_tdata,   // region_address[31:0], data_byte[39:32]
  input  wire logic [1:0]  in_tuser,   // opcode[1:0]
  input  wire logic        in_tlast,   // last_in_region
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [7:0]  out_tdata,  // out_char[7:0]
  input  wire logic        out_tuser,  // range_error
  input  wire logic        out_tlast,  // end_of_run
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  output int               fail_count,
  output int               pending_count,
  output int               chars_checked,
  output int               range_errors
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 40;
  localparam int PW = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
  localparam string HEX_DIGITS  = "0123456789ABCDEF";
  localparam string HEADER_LINE = "S00F000068656C6C6F202020202000003C";
  localparam string TERM_LINE_2 = "S9030000FC";
  localparam string TERM_LINE_3 = "S804000000FB";
  localparam string TERM_LINE_4 = "S70500000000FA";

  typedef struct packed {
    logic [7:0] ch;
    logic       eor;
    logic       err;
  } line_char_t;

  line_char_t expected_chars[$];

  // Shadow of the encoder's registers and region state.
  logic [2:0]  width_reg;
  logic [31:0] offset_reg;
  logic [7:0]  pending_data [DATA_BYTES];
  logic [4:0]  fill;
  logic [32:0] rec_addr;
  logic [7:0]  data_sum;
  logic        region_dead;

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic int unsigned width_now();
    if (width_reg < 3'd2) return 2;
    if (width_reg > 3'd4) return 4;
    return int'(width_reg);
  endfunction

  task automatic push_char(input logic [7:0] c, input logic err);
    line_char_t entry;
    entry.ch  = c;
    entry.eor = 1'b0;
    entry.err = err;
    expected_chars.insert(expected_chars.size(), entry);
  endtask

  task automatic push_hex(input logic [7:0] v);
    push_char(HEX_DIGITS[v[7:4]], 1'b0);
    push_char(HEX_DIGITS[v[3:0]], 1'b0);
  endtask

  task automatic push_line(input string s);
    for (int i = 0; i < s.len(); i++)
      push_char(s[i], 1'b0);
    push_char(8'h0A, 1'b0);
  endtask

  // Builds one data record from the pending bytes, or the single error
  // character when its last address falls outside the selected type.
  task automatic emit_record();
    int unsigned w;
    logic [63:0] top_addr;
    logic [63:0] last_addr;
    logic [7:0]  len;
    logic [7:0]  sum;
    logic [7:0]  b;
    w         = width_now();
    top_addr  = (64'd1 << (8 * w)) - 64'd1;
    last_addr = {31'd0, rec_addr} + 64'(fill) - 64'd1;
    if (last_addr > top_addr) begin
      push_char(8'h00, 1'b1);
      region_dead = 1'b1;
      fill        = '0;
      data_sum    = '0;
      return;
    end
    len = 8'(w + fill + 1);
    sum = len + data_sum;
    push_char("S", 1'b0);
    push_char(8'h30 + 8'(w - 1), 1'b0);
    push_hex(len);
    for (int i = int'(w); i > 0; i--) begin
      b = 8'(rec_addr >> (8 * (i - 1)));
      push_hex(b);
      sum = sum + b;
    end
    for (int i = 0; i < int'(fill); i++)
      push_hex(pending_data[i]);
    push_hex(~sum);
    push_char(8'h0A, 1'b0);
    rec_addr = rec_addr + 33'(fill);
    fill     = '0;
    data_sum = '0;
  endtask

  task automatic encode_item(input srle_pkg::op_t op, input logic [31:0] addr,
                             input logic [7:0] data_in, input logic last);
    int first;
    int unsigned w;
    first = expected_chars.size();
    case (op)
      srle_pkg::OP_HEADER: push_line(HEADER_LINE);
      srle_pkg::OP_START: begin
        fill        = '0;
        data_sum    = '0;
        region_dead = 1'b0;
        rec_addr    = {1'b0, addr} + {1'b0, offset_reg};
      end
      srle_pkg::OP_DATA: begin
        if (!region_dead) begin
          if (fill < DATA_BYTES) begin
            pending_data[fill[PW-1:0]] = data_in;
            fill     = fill + 5'd1;
            data_sum = data_sum + data_in;
          end
          if (fill >= DATA_BYTES || last)
            emit_record();
        end
      end
      default: begin
        w        = width_now();
        fill     = '0;
        data_sum = '0;
        push_line(w == 2 ? TERM_LINE_2 : (w == 3 ? TERM_LINE_3 : TERM_LINE_4));
      end
    endcase
    if (expected_chars.size() > first)
      expected_chars[expected_chars.size() - 1].eor = 1'b1;
  endtask

  task automatic check_char();
    line_char_t want;
    if (expected_chars.size() == 0) begin
      report_mismatch($sformatf("character %02h with nothing expected", out_tdata));
      return;
    end
    want = expected_chars.pop_front();
    if (out_tdata !== want.ch)
      report_mismatch($sformatf("out_char %02h, expected %02h (character %0d)",
                                out_tdata, want.ch, chars_checked));
    if (out_tlast !== want.eor)
      report_mismatch($sformatf("end_of_run %b, expected %b (character %0d)",
                                out_tlast, want.eor, chars_checked));
    if (out_tuser !== want.err)
      report_mismatch($sformatf("range_error %b, expected %b (character %0d)",
                                out_tuser, want.err, chars_checked));
    if (want.err)
      range_errors++;
    chars_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg     = 3'd2;
      offset_reg    = '0;
      fill          = '0;
      rec_addr      = '0;
      data_sum      = '0;
      region_dead   = 1'b0;
      fail_count    = 0;
      chars_checked = 0;
      range_errors  = 0;
      expected_chars.delete();
      pending_count <= 0;
    end else begin
      // Characters are checked before the new item is predicted, so an
      // unexpected character can never be matched by this edge's prediction.
      if (out_tvalid && out_tready)
        check_char();
      if (cfg_we) begin
        if (cfg_index == srle_pkg::REG_ADDRESS_BYTES)
          width_reg = cfg_wdata[2:0];
        else
          offset_reg = cfg_wdata;
      end
      if (in_tvalid && in_tready)
        encode_item(srle_pkg::op_t'(in_tuser), in_tdata[31:0], in_tdata[39:32],
                    in_tlast);
      pending_count <= expected_chars.size();
    end
  end

endmodule

/* tb/sv/srecord_line_encoder_unit_test.sv */
// ----------------------------------------------------------------------------
// srecord_line_encoder_unit_test: testbench top of the S-record line encoder
// Drives header, region, data and termination commands through a range of
// address widths and offsets, with random stalls on both streams, and leaves
// the checking to the scoreboard module beside the encoder.
// ----------------------------------------------------------------------------

module srecord_line_encoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RECORD_BYTES  = 16;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_ITEMS   = 36;
  // Cycles allowed after the last character for a command that prints nothing.
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 400;
  // Worst case: 310 items of 47 characters, each character held by the longest
  // receiver stall; the limit takes that several times over.
  localparam int CYCLE_LIMIT   = 1000000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // region_address[31:0], data_byte[39:32]
  logic [1:0]  in_tuser   = '0;   // opcode[1:0]
  logic        in_tlast   = 1'b0; // last_in_region
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // out_char[7:0]
  logic        out_tuser;         // range_error
  logic        out_tlast;         // end_of_run
  logic        cfg_we     = 1'b0;
  logic [0:0]  cfg_index  = '0;
  logic [31:0] cfg_wdata  = '0;

  int fail_count;
  int pending_count;
  int chars_checked;
  int range_errors;

  // Stimulus bookkeeping.
  int          items_sent = 0;
  int          cycle_count = 0;
  bit          tx_busy = 1'b1;    // sender draws random gaps while set
  bit          rx_busy = 1'b1;    // receiver draws random stalls while set
  bit          hold_req = 1'b0;   // asks the receiver for one long hold-off
  bit          hold_done = 1'b0;  // set by the receiver once it has held off
  int unsigned cur_width = 2;     // effective address width in bytes
  logic [31:0] cur_offset = '0;

  always #6 clk = ~clk;

  srecord_line_encoder_unit #(
    .RECORD_DATA_BYTES(RECORD_BYTES)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  srecord_line_encoder_unit_checker #(
    .DATA_BYTES(RECORD_BYTES)
  ) line_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .chars_checked (chars_checked),
    .range_errors  (range_errors)
  );

  // Offers one item after a random gap and waits until it is taken. All
  // inputs change by nonblocking assignment right after a rising edge, and
  // in_tready is sampled there too, so it holds the value seen at that edge.
  // A zero gap leaves in_tvalid high, so back-to-back items never see a
  // lowered valid inside one time step.
  task automatic send_item(input srle_pkg::op_t op, input logic [31:0] addr,
                           input logic [7:0] data, input logic last);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0)
      tx_busy = !tx_busy;
    gap = tx_busy ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {data, addr};
    in_tuser  <= op;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Stops offering and waits until every predicted character has arrived,
  // then waits out the settle time for a command that prints nothing. The
  // first edge is waited out because the scoreboard count is registered.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input srle_pkg::reg_idx_t idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Any command with every field random: stray data, early terminations,
  // extra headers and restarts in the middle of a region.
  task automatic noise_item();
    send_item(srle_pkg::op_t'($urandom_range(0, 3)), $urandom, 8'($urandom),
              1'($urandom));
  endtask

  // One well-formed region: a start, then a run of bytes with the last one
  // marked. Starts are often placed just below the top of the address range
  // so that records both reach it exactly and run past it. A few regions are
  // left unmarked or have noise mixed in. The run of bytes is cut short so
  // that the phase stays within its item budget.
  task automatic random_region(input int unsigned budget);
    logic [63:0] top_addr;
    logic [31:0] start;
    int unsigned count;
    bit          marked;
    top_addr = (64'd1 << (8 * cur_width)) - 64'd1;
    case ($urandom_range(0, 3))
      0:       start = 32'(top_addr - 64'($urandom_range(0, 40)) - 64'(cur_offset));
      3:       start = $urandom;
      default: start = ($urandom & top_addr[31:0]) - cur_offset;
    endcase
    send_item(srle_pkg::OP_START, start, 8'($urandom), 1'($urandom));
    // Mostly single records; now and then a region that spans several.
    count  = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
    if (count + 1 > budget)
      count = (budget > 1) ? budget - 1 : 1;
    marked = ($urandom_range(0, 9) != 0);
    for (int i = 0; i < int'(count); i++) begin
      if ($urandom_range(0, 24) == 0)
        noise_item();
      send_item(srle_pkg::OP_DATA, $urandom, 8'($urandom),
                (marked && i == int'(count) - 1) || ($urandom_range(0, 29) == 0));
    end
  endtask

  // Receiver: a random stall before every character, with stretches of none,
  // and one long hold-off on request while the sender keeps offering.
  initial begin
    int unsigned gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if ($urandom_range(0, 39) == 0)
          rx_busy = !rx_busy;
        gap = rx_busy ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d characters outstanding",
             cycle_count, pending_count);
    $display("srecord_line_encoder_unit_test: FAIL");
    $finish;
  end

  initial begin
    logic [2:0]  phase_width [NUM_PHASES];
    logic [31:0] phase_offset;
    int          phase_end;
    // Every address width code is visited, the out-of-range ones included.
    phase_width = '{3'd3, 3'd4, 3'd2, 3'd0, 3'd7, 3'd1, 3'd5, 3'd6};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset settings: 16-bit addresses, no offset.
    send_item(srle_pkg::OP_HEADER, $urandom, 8'($urandom), 1'b1);
    // Data before any region starts at address zero.
    send_item(srle_pkg::OP_DATA, 32'h0, 8'h00, 1'b1);
    // A record that ends exactly on the last 16-bit address.
    send_item(srle_pkg::OP_START, 32'h0000_FFFE, 8'hFF, 1'b0);
    send_item(srle_pkg::OP_DATA, 32'hFFFF_FFFF, 8'hFF, 1'b0);
    send_item(srle_pkg::OP_DATA, 32'h0, 8'h5A, 1'b1);
    // The region goes on past the end: one error, then silence.
    send_item(srle_pkg::OP_DATA, 32'h0, 8'h11, 1'b1);
    send_item(srle_pkg::OP_DATA, 32'h0, 8'h22, 1'b1);
    // A start far beyond the 16-bit range.
    send_item(srle_pkg::OP_START, 32'hFFFF_FFFF, 8'h00, 1'b1);
    send_item(srle_pkg::OP_DATA, 32'h0, 8'h80, 1'b1);
    // A termination drops the pending bytes but keeps the record address.
    send_item(srle_pkg::OP_START, 32'h0000_1234, 8'hFF, 1'b0);
    send_item(srle_pkg::OP_DATA, 32'h0, 8'h01, 1'b0);
    send_item(srle_pkg::OP_DATA, 32'h0, 8'h02, 1'b0);
    send_item(srle_pkg::OP_TERM, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    send_item(srle_pkg::OP_DATA, 32'h0, 8'h03, 1'b1);
    // A restart drops a partial record.
    send_item(srle_pkg::OP_START, 32'h0000_4000, 8'h00, 1'b0);
    send_item(srle_pkg::OP_DATA, 32'h0, 8'hAA, 1'b0);
    send_item(srle_pkg::OP_START, 32'h0000_5000, 8'h00, 1'b0);
    send_item(srle_pkg::OP_DATA, 32'h0, 8'h55, 1'b1);
    send_item(srle_pkg::OP_HEADER, 32'h0, 8'h00, 1'b0);
    send_item(srle_pkg::OP_TERM, 32'h0, 8'h00, 1'b0);

    // Random phases, each at its own width and offset. The drain before each
    // register write is also the point where the sender pauses until every
    // character has come back.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      case (p)
        0:       phase_offset = 32'h0000_0000;
        1:       phase_offset = 32'hFFFF_FFFF;
        3:       phase_offset = 32'hFFFF_0000;
        4:       phase_offset = 32'h00FF_FF00;
        6:       phase_offset = 32'h0000_0000;
        default: phase_offset = $urandom;
      endcase
      write_reg(srle_pkg::REG_ADDRESS_BYTES, {29'd0, phase_width[p]});
      write_reg(srle_pkg::REG_ADDR_OFFSET, phase_offset);
      cur_offset = phase_offset;
      if (phase_width[p] < 3'd2)
        cur_width = 2;
      else if (phase_width[p] > 3'd4)
        cur_width = 4;
      else
        cur_width = 32'(phase_width[p]);
      // In one phase the receiver stops for a long while, so the encoder
      // backs up and holds off the commands still being offered.
      if (p == 2)
        hold_req = 1'b1;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 7) == 0)
          noise_item();
        else
          random_region(unsigned'(phase_end - items_sent));
      end
    end

    drain();
    repeat (40) @(posedge clk);

    $display("Sent %0d commands over %0d register settings, all eight width codes;",
             items_sent, NUM_PHASES + 1);
    $display("checked %0d characters, %0d of them range errors.",
             chars_checked, range_errors);
    if (fail_count == 0 && pending_count == 0) begin
      $display("srecord_line_encoder_unit_test: PASS");
    end else begin
      $display("%0d mismatches, %0d characters outstanding", fail_count, pending_count);
      $display("srecord_line_encoder_unit_test: FAIL");
    end
    $finish;
  end

endmodule
